[design/kffc_pkg.sv]
// ----------------------------------------------------------------------------
// kffc_pkg
// Shared types, key codes and constants for the keypad four-function
// calculator.
// ----------------------------------------------------------------------------
package kffc_pkg;

    // field widths
    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int ANS_W    = 63;
    localparam int ENTRY_W  = 27;

    // parameter defaults
    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_MAX_DIGITS = 8;

    // key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 8'd9;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 8'd13;
    localparam logic [KEY_W-1:0] KEY_MUL       = 8'd42;
    localparam logic [KEY_W-1:0] KEY_ADD       = 8'd43;
    localparam logic [KEY_W-1:0] KEY_SUB       = 8'd45;
    localparam logic [KEY_W-1:0] KEY_DIV       = 8'd47;
    localparam logic [KEY_W-1:0] KEY_EQ        = 8'd61;

    // pending operator
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_ANSWER   = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_NO_OP    = 3'd4
    } t_status;

    // request from the key sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    // largest entry for a given number of digits, worked out at elaboration
    function automatic logic [ENTRY_W-1:0] entry_limit(input int digits);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < digits; i++) begin
            v = v * 64'd10;
        end
        return ENTRY_W'(v - 64'd1);
    endfunction

endpackage

[design/kffc_ifs.sv]
// ----------------------------------------------------------------------------
// kffc_ifs
// Valid/ready channels of the calculator: key items in, result items out.
// ----------------------------------------------------------------------------

// key channel
interface kffc_key_if import kffc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// result channel
interface kffc_res_if import kffc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [ANS_W-1:0] answer;

    modport source (output valid, output status, output answer, input ready);
    modport sink   (input valid, input status, input answer, output ready);
endinterface

[design/kffc_alu.sv]
// ----------------------------------------------------------------------------
// kffc_alu
// Iterative arithmetic unit: one shared 29-bit add/subtract stage under a
// step counter does add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module kffc_alu import kffc_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_alu_req           i_req,
    input  logic [ENTRY_W-1:0] i_opa,
    input  logic [ENTRY_W-1:0] i_opb,
    output logic               o_done,
    output logic [ANS_W-1:0]   o_result
);

    localparam int LW    = ENTRY_W + FRAC_BITS;
    localparam int ACC_W = ENTRY_W + 2;
    localparam int CNT_W = $clog2(LW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic [CNT_W-1:0]   r_cnt;
    logic [ACC_W-1:0]   r_hi;
    logic [LW-1:0]      r_lo;

    logic [ACC_W-1:0]   add_x;
    logic [ACC_W-1:0]   add_y;
    logic               add_sub;
    logic [ACC_W-1:0]   add_sum;

    // operand selection for the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                add_x = {2'b00, i_opa};
                add_y = {2'b00, i_opb};
            end
            OP_SUB: begin
                add_x   = {2'b00, i_opa};
                add_y   = {2'b00, i_opb};
                add_sub = 1'b1;
            end
            OP_MUL: begin
                add_x = r_hi;
                add_y = r_lo[FRAC_BITS] ? {2'b00, i_opa} : '0;
            end
            OP_DIV: begin
                // partial remainder shifted left with the next dividend bit
                add_x   = {1'b0, r_hi[ENTRY_W-1:0], r_lo[LW-1]};
                add_y   = {2'b00, i_opb};
                add_sub = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    // shared add/subtract stage
    assign add_sum = add_x + (add_y ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_hi    <= '0;
                        r_state <= S_RUN;
                        // multiplier or dividend sits in the top of the low word
                        r_lo    <= (i_req.op == OP_DIV) ? (LW'(i_opa) << FRAC_BITS)
                                                        : (LW'(i_opb) << FRAC_BITS);
                        unique case (i_req.op)
                            OP_MUL:  r_cnt <= CNT_W'(ENTRY_W - 1);
                            OP_DIV:  r_cnt <= CNT_W'(LW - 1);
                            default: r_cnt <= '0;
                        endcase
                    end
                end
                S_RUN: begin
                    unique case (r_op)
                        OP_ADD, OP_SUB: begin
                            r_hi <= add_sum;
                        end
                        OP_MUL: begin
                            r_hi <= {1'b0, add_sum[ACC_W-1:1]};
                            r_lo <= {add_sum[0], r_lo[LW-1:1]};
                        end
                        OP_DIV: begin
                            // keep the difference only when no borrow
                            r_hi <= add_sum[ACC_W-1] ? add_x : add_sum;
                            r_lo <= {r_lo[LW-2:0], ~add_sum[ACC_W-1]};
                        end
                        default: begin
                            r_hi <= r_hi;
                        end
                    endcase
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);

    // scale to fixed point
    always_comb begin
        unique case (r_op)
            OP_ADD, OP_SUB: o_result = ANS_W'($signed(r_hi)) << FRAC_BITS;
            OP_MUL:         o_result = ANS_W'({r_hi[ENTRY_W-1:0],
                                               r_lo[LW-1 -: ENTRY_W]}) << FRAC_BITS;
            OP_DIV:         o_result = ANS_W'(r_lo);
            default:        o_result = '0;
        endcase
    end

endmodule

[design/keypad_four_function_calculator.sv]
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Decimal keypad calculator: digits build an entry, an operator key keeps
// the first operand, '=' works out add, subtract, multiply or divide into a
// signed fixed-point answer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  i_key   | in  | valid / ready | key_code [7:0]
//  o_res   | out | valid / ready | status [2:0], answer [62:0] signed
//
//  digit, operator, clear and ignored keys: result item in the cycle after the key.
//  '=' with no operator or a zero divisor: the same; any other '=' starts kffc_alu and
//  the result item follows once its add, subtract, multiply or divide steps are done.
//  one key at a time: i_key.ready is low until the result item is taken.
//  synchronous reset clears entry, operand, operator and kept answer.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator import kffc_pkg::*; #(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kffc_key_if.sink   i_key,
    kffc_res_if.source o_res
);

    localparam logic [ENTRY_W-1:0] ENTRY_LIMIT = entry_limit(MAX_DIGITS);
    localparam int                 DSUM_W      = ENTRY_W + 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [ENTRY_W-1:0]  r_entry;
    logic [ENTRY_W-1:0]  r_first;
    t_op                 r_op;
    logic [ANS_W-1:0]    r_answer;
    logic [STATUS_W-1:0] r_status;

    logic                in_acc;
    logic [KEY_W-1:0]    key;
    logic                is_digit;
    logic                is_op_key;
    logic [DSUM_W-1:0]   digit_sum;
    logic [ENTRY_W-1:0]  n_entry;
    t_op                 key_op;
    t_alu_req            alu_req;
    logic                alu_done;
    logic [ANS_W-1:0]    alu_result;

    assign in_acc = i_key.valid && i_key.ready;
    assign key    = i_key.key_code;

    // key decode
    assign is_digit  = (key <= KEY_DIGIT_MAX);
    assign is_op_key = (key == KEY_ADD) || (key == KEY_SUB) ||
                       (key == KEY_MUL) || (key == KEY_DIV);

    always_comb begin
        priority case (key)
            KEY_ADD: key_op = OP_ADD;
            KEY_SUB: key_op = OP_SUB;
            KEY_MUL: key_op = OP_MUL;
            default: key_op = OP_DIV;
        endcase
    end

    // entry times ten plus digit, saturating
    assign digit_sum = (DSUM_W'(r_entry) << 3) + (DSUM_W'(r_entry) << 1)
                     + DSUM_W'(key[3:0]);
    assign n_entry   = (digit_sum > DSUM_W'(ENTRY_LIMIT)) ? ENTRY_LIMIT
                                                          : digit_sum[ENTRY_W-1:0];

    // start the arithmetic unit on '=' with a usable operator
    always_comb begin
        alu_req.op    = r_op;
        alu_req.start = in_acc && (key == KEY_EQ) && (r_op != OP_NONE) &&
                        !((r_op == OP_DIV) && (r_entry == '0));
    end

    kffc_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_opa    (r_first),
        .i_opb    (r_entry),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // key sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_entry  <= '0;
            r_first  <= '0;
            r_op     <= OP_NONE;
            r_answer <= '0;
            r_status <= ST_IGNORED;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_OUT;
                        priority if (is_digit) begin
                            r_entry  <= n_entry;
                            r_status <= ST_ACCEPTED;
                        end else if (is_op_key) begin
                            r_op     <= key_op;
                            r_first  <= r_entry;
                            r_entry  <= '0;
                            r_status <= ST_ACCEPTED;
                        end else if (key == KEY_EQ) begin
                            priority if (r_op == OP_NONE) begin
                                r_status <= ST_NO_OP;
                            end else if ((r_op == OP_DIV) && (r_entry == '0)) begin
                                r_status <= ST_DIV_ZERO;
                            end else begin
                                r_state <= S_CALC;
                            end
                        end else if (key == KEY_CLEAR) begin
                            r_entry  <= '0;
                            r_first  <= '0;
                            r_op     <= OP_NONE;
                            r_status <= ST_ACCEPTED;
                        end else begin
                            r_status <= ST_IGNORED;
                        end
                    end
                end
                S_CALC: begin
                    if (alu_done) begin
                        r_answer <= alu_result;
                        r_status <= ST_ANSWER;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_key.ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_OUT);
    assign o_res.status = r_status;
    assign o_res.answer = r_answer;

    // the arithmetic unit only finishes while a calculation is pending
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_CALC))
        else $error("arithmetic unit finished outside a calculation");

    // the entry never passes the saturation limit
    a_entry_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_digit |=> (r_entry <= ENTRY_LIMIT) && (r_status == ST_ACCEPTED))
        else $error("entry above its limit after a digit");

    // '=' with no operator reports it at once
    a_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (key == KEY_EQ) && (r_op == OP_NONE)
        |=> o_res.valid && (r_status == ST_NO_OP))
        else $error("missing operator not reported");

    // divide by zero keeps the answer
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (key == KEY_EQ) && (r_op == OP_DIV) && (r_entry == '0)
        |=> (r_status == ST_DIV_ZERO) && (r_answer == $past(r_answer)))
        else $error("divide by zero changed the kept answer");

endmodule

[bench/keypad_four_function_calculator_tb.sv]
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_tb
// Self-checking bench for the keypad calculator. A queue of key codes is
// filled up front: a short directed run (no-operator equals, ignored codes,
// entry saturation, largest product, repeated equals, divide by zero,
// division, negative difference, clear) and then random keypad sequences
// with some noise and broken sequences. A clocked driver sends the keys in
// bursts, a clocked monitor checks every result item against an in-bench
// model of the calculator while the result channel stalls on its own pattern.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_tb import kffc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               FRAC        = DEF_FRAC_BITS;
    localparam logic [63:0]      ENTRY_MAX   = 64'd99999999;
    localparam int               N_RANDOM    = 1600;
    localparam int               IDLE_LIMIT  = 1000;
    localparam int               DRAIN_CYCLES = 64;

    typedef struct {
        t_status           status;
        logic [ANS_W-1:0]  answer;
    } t_calc_result;

    logic i_clk;
    logic i_rst_n;

    kffc_key_if key_if ();
    kffc_res_if res_if ();

    keypad_four_function_calculator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_res   (res_if)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // pending keys and expected result items
    logic [KEY_W-1:0] key_q[$];
    t_calc_result     result_expect_q[$];

    // calculator model state
    logic [ENTRY_W-1:0] calc_entry;
    logic [ENTRY_W-1:0] calc_first;
    t_op                calc_op;
    logic [ANS_W-1:0]   calc_answer;

    // bookkeeping
    int fail_count;
    int n_meaningful;
    int n_keys_total;
    int n_keys_sent;
    int n_checked;
    int n_answers;
    int n_div_zero;
    int n_no_op;
    int idle_cycles;
    logic key_taken;

    // sender burst control
    int burst_left;
    int gap_left;

    // receiver stall control
    int          rx_mode;
    int          rx_mode_left;
    int          rx_hold_left;
    logic [15:0] rx_pattern;
    bit          rx_long;

    // model: apply one key, queue the expected result item
    task automatic calc_apply_key(input logic [KEY_W-1:0] key);
        logic [63:0]  wide;
        logic [63:0]  a;
        logic [63:0]  b;
        t_calc_result exp;
        a = 64'(calc_first);
        b = 64'(calc_entry);
        exp.status = ST_IGNORED;
        if (key <= KEY_DIGIT_MAX) begin
            wide = b * 64'd10 + 64'(key);
            calc_entry = (wide > ENTRY_MAX) ? ENTRY_W'(ENTRY_MAX) : ENTRY_W'(wide);
            exp.status = ST_ACCEPTED;
        end else if (key == KEY_ADD || key == KEY_SUB || key == KEY_MUL ||
                     key == KEY_DIV) begin
            case (key)
                KEY_ADD: calc_op = OP_ADD;
                KEY_SUB: calc_op = OP_SUB;
                KEY_MUL: calc_op = OP_MUL;
                default: calc_op = OP_DIV;
            endcase
            calc_first = calc_entry;
            calc_entry = '0;
            exp.status = ST_ACCEPTED;
        end else if (key == KEY_EQ) begin
            case (calc_op)
                OP_ADD: begin
                    calc_answer = ANS_W'((a + b) << FRAC);
                    exp.status  = ST_ANSWER;
                end
                OP_SUB: begin
                    calc_answer = ANS_W'((a - b) << FRAC);
                    exp.status  = ST_ANSWER;
                end
                OP_MUL: begin
                    calc_answer = ANS_W'((a * b) << FRAC);
                    exp.status  = ST_ANSWER;
                end
                OP_DIV: begin
                    if (b != 64'd0) begin
                        calc_answer = ANS_W'((a << FRAC) / b);
                        exp.status  = ST_ANSWER;
                    end else begin
                        exp.status = ST_DIV_ZERO;
                    end
                end
                default: exp.status = ST_NO_OP;
            endcase
        end else if (key == KEY_CLEAR) begin
            calc_entry = '0;
            calc_first = '0;
            calc_op    = OP_NONE;
            exp.status = ST_ACCEPTED;
        end
        exp.answer = calc_answer;
        result_expect_q.push_back(exp);
    endtask

    // stimulus helpers
    task automatic push_key(input logic [KEY_W-1:0] key);
        key_q.push_back(key);
        if (key <= KEY_DIGIT_MAX || key == KEY_ADD || key == KEY_SUB ||
            key == KEY_MUL || key == KEY_DIV || key == KEY_EQ || key == KEY_CLEAR) begin
            n_meaningful++;
        end
    endtask

    task automatic push_digits(input int count, input int digit);
        repeat (count) push_key(KEY_W'(digit));
    endtask

    // random number of digits: mostly short, sometimes long enough to saturate
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 90) return $urandom_range(4, 8);
        return $urandom_range(9, 11);
    endfunction

    task automatic push_number(input int count);
        repeat (count) push_key(KEY_W'($urandom_range(0, 9)));
    endtask

    function automatic logic [KEY_W-1:0] pick_op_key();
        case ($urandom_range(0, 3))
            0:       return KEY_ADD;
            1:       return KEY_SUB;
            2:       return KEY_MUL;
            default: return KEY_DIV;
        endcase
    endfunction

    // build the whole key sequence
    task automatic build_stimulus();
        int r;
        // directed part
        push_key(KEY_EQ);                 // equals with no operator
        push_key(8'hFF);                  // ignored codes
        push_key(8'd10);
        push_digits(9, 9);                // entry saturates
        push_key(KEY_MUL);                // largest product
        push_digits(8, 9);
        push_key(KEY_EQ);
        push_key(KEY_EQ);                 // equals again keeps operands
        push_key(KEY_DIV);                // divide by zero
        push_key(KEY_EQ);
        push_key(8'd7);                   // division with fraction bits
        push_key(KEY_EQ);
        push_key(KEY_SUB);                // negative difference
        push_key(8'd9);
        push_key(KEY_EQ);
        push_key(KEY_CLEAR);
        // random part
        while (n_meaningful < N_RANDOM + 30) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                // well-formed calculation
                push_number(pick_len());
                push_key(pick_op_key());
                push_number(pick_len());
                push_key(KEY_EQ);
                if ($urandom_range(0, 4) == 0) push_key(KEY_EQ);
                if ($urandom_range(0, 9) == 0) push_key(KEY_CLEAR);
            end else if (r < 84) begin
                // chain on the current entry
                push_key(pick_op_key());
                push_number(pick_len());
                push_key(KEY_EQ);
            end else if (r < 94) begin
                // noise over the full code range
                repeat ($urandom_range(1, 4)) push_key(KEY_W'($urandom_range(0, 255)));
            end else if (r < 97) begin
                // equals after clear, no operator
                push_key(KEY_CLEAR);
                push_number(pick_len());
                push_key(KEY_EQ);
            end else begin
                // operator pressed twice
                push_number(pick_len());
                push_key(pick_op_key());
                push_key(pick_op_key());
                push_key(KEY_EQ);
            end
        end
    endtask

    // key driver: bursts with random gaps, changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_if.valid    <= 1'b0;
            key_if.key_code <= '0;
        end else if (!key_if.valid || key_taken) begin
            if (gap_left > 0) begin
                key_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (key_q.size() != 0) begin
                key_if.key_code <= key_q.pop_front();
                key_if.valid    <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(0, 30)
                                                               : $urandom_range(0, 3);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                key_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: switches between stall modes, always ready, a rotating pattern or random holds
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(50, 400);
            rx_pattern   <= 16'($urandom) | 16'h0001;
            res_if.ready <= 1'b1;
        end else begin
            rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: begin
                    res_if.ready <= rx_pattern[0];
                    rx_pattern   <= {rx_pattern[0], rx_pattern[15:1]};
                end
                default: begin
                    if (rx_hold_left == 0) begin
                        rx_long       = ($urandom_range(0, 3) == 0);
                        res_if.ready <= !rx_long;
                        rx_hold_left <= rx_long ? $urandom_range(5, 40) : $urandom_range(0, 6);
                    end else begin
                        rx_hold_left <= rx_hold_left - 1;
                    end
                end
            endcase
        end
    end

    // key side monitor: feed the model with every accepted key
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_taken <= 1'b0;
        end else begin
            key_taken <= key_if.valid && key_if.ready;
            if (key_if.valid && key_if.ready) begin
                calc_apply_key(key_if.key_code);
                n_keys_sent++;
            end
        end
    end

    // result side monitor: compare with the oldest expected item
    always @(posedge i_clk) begin
        t_calc_result exp;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (result_expect_q.size() == 0) begin
                $display("%0t: unexpected result item, status %0d answer %0d",
                         $realtime, res_if.status, $signed(res_if.answer));
                fail_count++;
            end else begin
                exp = result_expect_q.pop_front();
                n_checked++;
                if (res_if.status !== exp.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $realtime, exp.status, res_if.status);
                    fail_count++;
                end
                if (res_if.answer !== exp.answer) begin
                    $display("%0t: answer mismatch, expected %0d, actual %0d",
                             $realtime, $signed(exp.answer), $signed(res_if.answer));
                    fail_count++;
                end
                case (exp.status)
                    ST_ANSWER:   n_answers++;
                    ST_DIV_ZERO: n_div_zero++;
                    ST_NO_OP:    n_no_op++;
                    default:     ;
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("keypad_four_function_calculator_tb: FAIL");
                $finish;
            end
        end
    end

    // reset, stimulus and end of run
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        key_if.valid    = 1'b0;
        key_if.key_code = '0;
        res_if.ready    = 1'b0;
        calc_entry      = '0;
        calc_first      = '0;
        calc_op         = OP_NONE;
        calc_answer     = '0;
        fail_count      = 0;
        n_meaningful    = 0;
        n_keys_total    = 0;
        n_keys_sent     = 0;
        n_checked       = 0;
        n_answers       = 0;
        n_div_zero      = 0;
        n_no_op         = 0;
        idle_cycles     = 0;
        key_taken       = 1'b0;
        burst_left      = 1;
        gap_left        = 0;
        rx_mode         = 0;
        rx_mode_left    = 0;
        rx_hold_left    = 0;
        rx_pattern      = 16'h0001;
        rx_long         = 1'b0;

        build_stimulus();
        n_keys_total = key_q.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every key to be accepted, then for every result item
        @(negedge i_clk);
        while (n_keys_sent < n_keys_total) @(negedge i_clk);
        while (result_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d keys and %0d result items checked", n_keys_sent, n_checked);
        $display("of those %0d answers, %0d divides by zero, %0d equals with no operator",
                 n_answers, n_div_zero, n_no_op);
        if (fail_count == 0) begin
            $display("keypad_four_function_calculator_tb: PASS");
        end else begin
            $display("keypad_four_function_calculator_tb: FAIL");
        end
        $finish;
    end

endmodule

[keypad_four_function_calculator.f]
design/kffc_pkg.sv
design/kffc_ifs.sv
design/kffc_alu.sv
design/keypad_four_function_calculator.sv
bench/keypad_four_function_calculator_tb.sv
